// ===== hdl/mlfq_pkg.sv =====
// Package for the multilevel feedback queue scheduler.
// Holds field widths, codes, item and control structs and the time helpers.
// No dependencies.
package mlfq_pkg;

   // Sizes and widths.
   localparam int MAX_PROCS_DEFAULT = 16;
   localparam int LEVELS = 3;
   localparam int TIME_W = 20;
   localparam int BURST_W = 16;
   localparam int QUANT_W = 8;
   localparam int PWAIT_W = 16;
   localparam int SLOT_OUT_W = 4;
   localparam int LEVEL_W = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = 20'hFFFFF;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_LEVEL0 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_LEVEL1 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM_LEVEL2 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMOTE_AFTER = 4'd3;

   // Reset values of the configuration registers.
   localparam logic [QUANT_W-1:0] QUANTUM_LEVEL0_RESET = 8'd2;
   localparam logic [QUANT_W-1:0] QUANTUM_LEVEL1_RESET = 8'd4;
   localparam logic [QUANT_W-1:0] QUANTUM_LEVEL2_RESET = 8'd8;
   localparam logic [PWAIT_W-1:0] PROMOTE_AFTER_RESET = 16'd10;

   // Queue level codes.
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MID = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_BOTTOM = 2'd2;

   // Action codes.
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_STEP = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [TIME_W-1:0]    arrive_at;
      logic [BURST_W-1:0]   burst_len;
   } req_item_type;

   typedef struct packed {
      logic                  served;
      logic [SLOT_OUT_W-1:0] served_slot;
      logic [LEVEL_W-1:0]    served_level;
      logic [QUANT_W-1:0]    run_length;
      logic                  finished;
      logic [TIME_W-1:0]     waiting_total;
      logic [TIME_W-1:0]     turnaround;
      logic [TIME_W-1:0]     now;
      logic                  all_done;
      logic                  table_full;
   } rsp_item_type;

   typedef struct packed {
      logic [QUANT_W-1:0] quantum_level0;
      logic [QUANT_W-1:0] quantum_level1;
      logic [QUANT_W-1:0] quantum_level2;
      logic [PWAIT_W-1:0] promote_after;
   } cfg_type;

   // One entry of the process table.
   typedef struct packed {
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] remaining;
      logic [TIME_W-1:0]  last_run;
      logic [TIME_W-1:0]  waiting;
   } slot_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ADM_RD,
      ST_ADM_CHK,
      ST_PICK,
      ST_QRD,
      ST_POP,
      ST_SLOT_RD,
      ST_SERVE,
      ST_ADM2_RD,
      ST_ADM2_CHK,
      ST_REQUEUE,
      ST_PR_TEST,
      ST_PR_POP,
      ST_PR_SLOT,
      ST_PR_CHK,
      ST_RESP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load;
      logic scan_init;
      logic scan_chk;
      logic rd_scan;
      logic tick;
      logic pick;
      logic pop;
      logic serve;
      logic requeue;
      logic pr_init_mid;
      logic pr_init_bottom;
      logic pr_chk;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic nothing_left;
      logic any_queued;
      logic scan_done;
      logic pr_done;
      logic pr_at_bottom;
   } ctrl_status_type;

   // Saturating add of two time values.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   // Difference that stops at zero.
   function automatic logic [TIME_W-1:0] diff_floor(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
      return (a >= b) ? (a - b) : '0;
   endfunction

endpackage

// ===== hdl/mlfq_scheduler_unit.sv =====
// Top level of the three-level feedback queue scheduler.
// Depends on mlfq_pkg, mlfq_csr, mlfq_ctrl and mlfq_datapath.
//
//  Channel  Ports                          Handshake
//  request  start, busy, req_item          taken when start is high and busy low
//  result   rsp_strobe, rsp_item           one cycle per item, cannot be held off
//  config   csr_valid, csr_ready, csr_*    taken when valid and ready are high
//
// A step that serves runs two admission scans of the process table and a
// promotion sweep of the entries queued in the middle and bottom levels when
// the sweep opens, each bound by the single read port of the table memory.
// A step that only advances time runs just the first admission scan, and a
// step when nothing is left runs neither. busy stays high until the result strobe.
// Reset is synchronous; all queues and slots are empty after it.
module mlfq_scheduler_unit import mlfq_pkg::*; #(
   parameter int MAX_PROCS = MAX_PROCS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   mlfq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mlfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_item.action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mlfq_datapath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

// ===== hdl/mlfq_csr.sv =====
// Configuration registers of the scheduler: three quanta and the promotion wait.
// Depends on mlfq_pkg.
module mlfq_csr import mlfq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Next register values; unknown indexes change nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_QUANTUM_LEVEL0: cfg_in.quantum_level0 = csr_data[QUANT_W-1:0];
            CSR_QUANTUM_LEVEL1: cfg_in.quantum_level1 = csr_data[QUANT_W-1:0];
            CSR_QUANTUM_LEVEL2: cfg_in.quantum_level2 = csr_data[QUANT_W-1:0];
            CSR_PROMOTE_AFTER: cfg_in.promote_after = csr_data[PWAIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quantum_level0 <= QUANTUM_LEVEL0_RESET;
         cfg_ff.quantum_level1 <= QUANTUM_LEVEL1_RESET;
         cfg_ff.quantum_level2 <= QUANTUM_LEVEL2_RESET;
         cfg_ff.promote_after <= PROMOTE_AFTER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/mlfq_ctrl.sv =====
// Controller state machine of the scheduler: sequences load, admission scans,
// service, requeue and the promotion sweep. Depends on mlfq_pkg.
module mlfq_ctrl import mlfq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            action,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_strobe
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (action == ACTION_LOAD) begin
                  state_in = ST_LOAD;
               end else if (status.nothing_left) begin
                  state_in = ST_RESP;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in = ST_ADM_RD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_RESP;
         end
         ST_ADM_RD: begin
            cmd.rd_scan = 1'b1;
            state_in = status.scan_done ? ST_PICK : ST_ADM_CHK;
         end
         ST_ADM_CHK: begin
            cmd.rd_scan = 1'b1;
            cmd.scan_chk = 1'b1;
            state_in = ST_ADM_RD;
         end
         ST_PICK: begin
            if (status.any_queued) begin
               cmd.pick = 1'b1;
               state_in = ST_QRD;
            end else begin
               cmd.tick = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_QRD: begin
            state_in = ST_POP;
         end
         ST_POP: begin
            cmd.pop = 1'b1;
            state_in = ST_SLOT_RD;
         end
         ST_SLOT_RD: begin
            state_in = ST_SERVE;
         end
         ST_SERVE: begin
            cmd.serve = 1'b1;
            cmd.scan_init = 1'b1;
            state_in = ST_ADM2_RD;
         end
         ST_ADM2_RD: begin
            cmd.rd_scan = 1'b1;
            state_in = status.scan_done ? ST_REQUEUE : ST_ADM2_CHK;
         end
         ST_ADM2_CHK: begin
            cmd.rd_scan = 1'b1;
            cmd.scan_chk = 1'b1;
            state_in = ST_ADM2_RD;
         end
         ST_REQUEUE: begin
            cmd.requeue = 1'b1;
            cmd.pr_init_mid = 1'b1;
            state_in = ST_PR_TEST;
         end
         // This cycle also reads the head of the level being swept.
         ST_PR_TEST: begin
            if (!status.pr_done) begin
               state_in = ST_PR_POP;
            end else if (status.pr_at_bottom) begin
               state_in = ST_RESP;
            end else begin
               cmd.pr_init_bottom = 1'b1;
               state_in = ST_PR_TEST;
            end
         end
         ST_PR_POP: begin
            cmd.pop = 1'b1;
            state_in = ST_PR_SLOT;
         end
         ST_PR_SLOT: begin
            state_in = ST_PR_CHK;
         end
         ST_PR_CHK: begin
            cmd.pr_chk = 1'b1;
            state_in = ST_PR_TEST;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/mlfq_datapath.sv =====
// Datapath of the scheduler: process table memory, level queue memory,
// queue pointers, time, scan counters and result registers. Depends on mlfq_pkg.
module mlfq_datapath import mlfq_pkg::*; #(
   parameter int MAX_PROCS = MAX_PROCS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   input  cfg_type         cfg,
   input  req_item_type    req_item,
   output ctrl_status_type status,
   output rsp_item_type    rsp_item
);

   localparam int SW = $clog2(MAX_PROCS);
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int QAW = $clog2(LEVELS * MAX_PROCS);

   // Memories.
   slot_entry_type slot_mem [MAX_PROCS];
   logic [SW-1:0]  q_mem [LEVELS * MAX_PROCS];
   slot_entry_type slot_rd_ff;
   logic [SW-1:0]  q_rd_ff;

   // Control state.
   logic [CW-1:0]        loaded_ff, loaded_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [MAX_PROCS-1:0] pending_ff, pending_in;
   logic [SW-1:0]        head_ff [LEVELS];
   logic [SW-1:0]        head_in [LEVELS];
   logic [CW-1:0]        cnt_ff [LEVELS];
   logic [CW-1:0]        cnt_in [LEVELS];
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        pr_cnt_ff, pr_cnt_in;
   logic [LEVEL_W-1:0]   cur_lvl_ff, cur_lvl_in;

   // Payload state.
   req_item_type         req_ff;
   logic [SW-1:0]        slot_ff;
   logic [LEVEL_W-1:0]   push_lvl_ff;
   logic                 res_served_ff;
   logic [SW-1:0]        res_slot_ff;
   logic [LEVEL_W-1:0]   res_level_ff;
   logic [QUANT_W-1:0]   res_run_ff;
   logic                 res_finished_ff;
   logic [TIME_W-1:0]    res_wait_ff;
   logic [TIME_W-1:0]    res_turn_ff;
   logic                 res_full_ff;

   // Combinational values.
   logic [SW-1:0]        scan_slot;
   logic                 adm_hit;
   logic                 table_full;
   logic [QUANT_W-1:0]   quantum;
   logic                 full_slice;
   logic [QUANT_W-1:0]   run;
   logic [BURST_W-1:0]   new_rem;
   logic [TIME_W-1:0]    new_time;
   logic [TIME_W-1:0]    wait_new;
   logic [TIME_W-1:0]    turn;
   logic                 promo_hit;
   logic [SW-1:0]        tail [LEVELS];
   logic [CW:0]          tail_sum [LEVELS];
   logic                 any_queued;
   logic [LEVEL_W-1:0]   top_lvl;
   logic                 push_en;
   logic [LEVEL_W-1:0]   push_lvl;
   logic [SW-1:0]        push_slot;
   logic [SW-1:0]        push_tail;
   logic [SW-1:0]        cur_head;
   logic [QAW-1:0]       q_wr_addr;
   logic [QAW-1:0]       q_rd_addr;
   logic [SW-1:0]        slot_rd_addr;
   logic                 slot_we;
   logic [SW-1:0]        slot_wr_addr;
   slot_entry_type       slot_wr_data;

   assign scan_slot = idx_ff[SW-1:0];
   assign table_full = (loaded_ff >= CW'(MAX_PROCS));

   // Admission test for the slot under the scan.
   assign adm_hit = pending_ff[scan_slot] && (slot_rd_ff.arrival <= time_ff);

   // Slice of the served process.
   always_comb begin
      case (cur_lvl_ff)
         LEVEL_TOP: quantum = cfg.quantum_level0;
         LEVEL_MID: quantum = cfg.quantum_level1;
         default:   quantum = cfg.quantum_level2;
      endcase
   end

   assign full_slice = (slot_rd_ff.remaining >= BURST_W'(quantum));
   assign run = full_slice ? quantum : slot_rd_ff.remaining[QUANT_W-1:0];
   assign new_rem = slot_rd_ff.remaining - BURST_W'(run);
   assign new_time = sat_add(time_ff, TIME_W'(run));
   assign wait_new = sat_add(slot_rd_ff.waiting,
                             diff_floor(time_ff, slot_rd_ff.last_run));
   assign turn = diff_floor(new_time, slot_rd_ff.arrival);
   assign promo_hit = (diff_floor(time_ff, slot_rd_ff.last_run) >=
                       TIME_W'(cfg.promote_after));

   // Tail position of each level, wrapped into the ring.
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         tail_sum[l] = (CW+1)'(head_ff[l]) + (CW+1)'(cnt_ff[l]);
         if (tail_sum[l] >= (CW+1)'(MAX_PROCS)) begin
            tail_sum[l] = tail_sum[l] - (CW+1)'(MAX_PROCS);
         end
         tail[l] = tail_sum[l][SW-1:0];
      end
   end

   assign any_queued = (cnt_ff[0] != '0) || (cnt_ff[1] != '0) || (cnt_ff[2] != '0);
   assign top_lvl = (cnt_ff[0] != '0) ? LEVEL_TOP :
                    (cnt_ff[1] != '0) ? LEVEL_MID : LEVEL_BOTTOM;

   // Head of the current level.
   always_comb begin
      case (cur_lvl_ff)
         LEVEL_TOP: cur_head = head_ff[0];
         LEVEL_MID: cur_head = head_ff[1];
         default:   cur_head = head_ff[2];
      endcase
   end

   // Queue push source: admission, requeue of the served item, or the promotion sweep.
   always_comb begin
      push_en = 1'b0;
      push_lvl = LEVEL_TOP;
      push_slot = slot_ff;
      if (cmd.scan_chk && adm_hit) begin
         push_en = 1'b1;
         push_slot = scan_slot;
      end else if (cmd.requeue && !res_finished_ff) begin
         push_en = 1'b1;
         push_lvl = push_lvl_ff;
      end else if (cmd.pr_chk) begin
         push_en = 1'b1;
         push_lvl = promo_hit ? (cur_lvl_ff - 2'd1) : cur_lvl_ff;
      end
   end

   always_comb begin
      case (push_lvl)
         LEVEL_TOP: push_tail = tail[0];
         LEVEL_MID: push_tail = tail[1];
         default:   push_tail = tail[2];
      endcase
   end

   assign q_wr_addr = QAW'(push_lvl) * QAW'(MAX_PROCS) + QAW'(push_tail);
   assign q_rd_addr = QAW'(cur_lvl_ff) * QAW'(MAX_PROCS) + QAW'(cur_head);

   // Level queue memory.
   always_ff @(posedge clock) begin
      if (push_en) begin
         q_mem[q_wr_addr] <= push_slot;
      end
      q_rd_ff <= q_mem[q_rd_addr];
   end

   // Process table port selection.
   assign slot_rd_addr = cmd.rd_scan ? scan_slot : slot_ff;
   assign slot_we = (cmd.load && !table_full) || cmd.serve;
   assign slot_wr_addr = cmd.serve ? slot_ff : loaded_ff[SW-1:0];

   always_comb begin
      if (cmd.serve) begin
         slot_wr_data.arrival = slot_rd_ff.arrival;
         slot_wr_data.remaining = new_rem;
         slot_wr_data.last_run = new_time;
         slot_wr_data.waiting = wait_new;
      end else begin
         slot_wr_data.arrival = req_ff.arrive_at;
         slot_wr_data.remaining = req_ff.burst_len;
         slot_wr_data.last_run = req_ff.arrive_at;
         slot_wr_data.waiting = '0;
      end
   end

   // Process table memory.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
      slot_rd_ff <= slot_mem[slot_rd_addr];
   end

   // Next values of the control state.
   always_comb begin
      loaded_in = loaded_ff;
      time_in = time_ff;
      pending_in = pending_ff;
      idx_in = idx_ff;
      pr_cnt_in = pr_cnt_ff;
      cur_lvl_in = cur_lvl_ff;

      if (cmd.load && !table_full) begin
         loaded_in = loaded_ff + 1'b1;
         pending_in[loaded_ff[SW-1:0]] = 1'b1;
      end
      if (cmd.scan_chk && adm_hit) begin
         pending_in[scan_slot] = 1'b0;
      end
      if (cmd.scan_init) begin
         idx_in = '0;
      end else if (cmd.scan_chk) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.tick) begin
         time_in = sat_add(time_ff, TIME_W'(1));
      end else if (cmd.serve) begin
         time_in = new_time;
      end
      if (cmd.pick) begin
         cur_lvl_in = top_lvl;
      end else if (cmd.pr_init_mid) begin
         cur_lvl_in = LEVEL_MID;
      end else if (cmd.pr_init_bottom) begin
         cur_lvl_in = LEVEL_BOTTOM;
      end

      for (int l = 0; l < LEVELS; l++) begin
         head_in[l] = head_ff[l];
         cnt_in[l] = cnt_ff[l];
         if (push_en && (push_lvl == LEVEL_W'(l))) begin
            cnt_in[l] = cnt_ff[l] + 1'b1;
         end
         if (cmd.pop && (cur_lvl_ff == LEVEL_W'(l))) begin
            cnt_in[l] = cnt_ff[l] - 1'b1;
            head_in[l] = (head_ff[l] == SW'(MAX_PROCS - 1)) ? '0 : head_ff[l] + 1'b1;
         end
      end

      // The sweep length is the count of the level when its sweep opens.
      if (cmd.pr_init_mid) begin
         pr_cnt_in = cnt_in[1];
      end else if (cmd.pr_init_bottom) begin
         pr_cnt_in = cnt_ff[2];
      end else if (cmd.pop && (pr_cnt_ff != '0)) begin
         pr_cnt_in = pr_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         time_ff <= '0;
         pending_ff <= '0;
         idx_ff <= '0;
         pr_cnt_ff <= '0;
         cur_lvl_ff <= LEVEL_TOP;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= '0;
            cnt_ff[l] <= '0;
         end
      end else begin
         loaded_ff <= loaded_in;
         time_ff <= time_in;
         pending_ff <= pending_in;
         idx_ff <= idx_in;
         pr_cnt_ff <= pr_cnt_in;
         cur_lvl_ff <= cur_lvl_in;
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l] <= head_in[l];
            cnt_ff[l] <= cnt_in[l];
         end
      end
   end

   // Item capture, popped slot and result registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_item;
         res_served_ff <= 1'b0;
         res_slot_ff <= '0;
         res_level_ff <= LEVEL_TOP;
         res_run_ff <= '0;
         res_finished_ff <= 1'b0;
         res_wait_ff <= '0;
         res_turn_ff <= '0;
         res_full_ff <= 1'b0;
      end
      if (cmd.load && table_full) begin
         res_full_ff <= 1'b1;
      end
      if (cmd.pop) begin
         slot_ff <= q_rd_ff;
      end
      if (cmd.serve) begin
         res_served_ff <= 1'b1;
         res_slot_ff <= slot_ff;
         res_level_ff <= cur_lvl_ff;
         res_run_ff <= run;
         res_finished_ff <= (new_rem == '0);
         res_wait_ff <= wait_new;
         res_turn_ff <= (new_rem == '0) ? turn : '0;
         push_lvl_ff <= (full_slice && (cur_lvl_ff != LEVEL_BOTTOM)) ?
                        (cur_lvl_ff + 2'd1) : cur_lvl_ff;
      end
   end

   // Status to the controller.
   assign status.nothing_left = (pending_ff == '0) && !any_queued;
   assign status.any_queued = any_queued;
   assign status.scan_done = (idx_ff >= loaded_ff);
   assign status.pr_done = (pr_cnt_ff == '0);
   assign status.pr_at_bottom = (cur_lvl_ff == LEVEL_BOTTOM);

   // Result item.
   assign rsp_item.served = res_served_ff;
   assign rsp_item.served_slot = SLOT_OUT_W'(res_slot_ff);
   assign rsp_item.served_level = res_level_ff;
   assign rsp_item.run_length = res_run_ff;
   assign rsp_item.finished = res_finished_ff;
   assign rsp_item.waiting_total = res_wait_ff;
   assign rsp_item.turnaround = res_turn_ff;
   assign rsp_item.now = time_ff;
   assign rsp_item.all_done = status.nothing_left;
   assign rsp_item.table_full = res_full_ff;

endmodule

// ===== hdl/mlfq_checker.sv =====
// Port-level checks on the scheduler and the bind that attaches them.
// Depends on mlfq_pkg and mlfq_scheduler_unit.
module mlfq_checker import mlfq_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input req_item_type          req_item,
   input logic                  rsp_strobe,
   input rsp_item_type          rsp_item,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted item");

   // A result ends the item: the block is free in the next cycle.
   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("block still busy after a result");

   // A refused load reports no service.
   a_full_no_serve: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.table_full) |-> !rsp_item.served)
      else $error("refused load reports a service");

   // A finished process has run to the end of its burst in a service.
   a_finish_served: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.finished) |-> rsp_item.served)
      else $error("finish reported without a service");

   // Nothing served means no run length.
   a_idle_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.served) |-> (rsp_item.run_length == '0))
      else $error("run length without a service");

endmodule

bind mlfq_scheduler_unit mlfq_checker u_checker (.*);
